@@ rtl/core/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants, codes and types of the multi-slot timer scheduler.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
	localparam int ID_BITS     = 4;
	localparam int TICK_BITS   = 24;
	localparam int COUNT_BITS  = 16;
	localparam int MAX_RESULTS = 32;
	localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);

	// request function codes
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_ADD_ONCE = 3'd1;
	localparam logic [2:0] FN_ADD_REP  = 3'd2;
	localparam logic [2:0] FN_ADD_LIM  = 3'd3;
	localparam logic [2:0] FN_CANCEL   = 3'd4;
	localparam logic [2:0] FN_NEW_IVL  = 3'd5;

	// slot modes
	localparam logic [1:0] MODE_ONCE    = 2'd0;
	localparam logic [1:0] MODE_REPEAT  = 2'd1;
	localparam logic [1:0] MODE_LIMITED = 2'd2;

	typedef enum logic [1:0] {
		EV_ACCEPT = 2'd0,
		EV_REJECT = 2'd1,
		EV_FIRED  = 2'd2,
		EV_FINAL  = 2'd3
	} ev_kind_t;

	// timing memory entry
	typedef struct packed {
		logic [TICK_BITS-1:0] ticks_left;
		logic [TICK_BITS-1:0] reload;
	} tmr_entry_t;

	// control memory entry
	typedef struct packed {
		logic [COUNT_BITS-1:0] limit;
		logic [COUNT_BITS-1:0] count;
		logic [1:0]            mode;
		logic                  final_req;
	} ctl_entry_t;

	localparam int TMR_W = $bits(tmr_entry_t);
	localparam int CTL_W = $bits(ctl_entry_t);

	// controller -> result stage
	typedef struct packed {
		logic                 push;
		logic                 flush;
		ev_kind_t             kind;
		logic [SLOT_BITS-1:0] slot;
	} res_req_t;

	// result stage -> controller
	typedef struct packed {
		logic room;
		logic flush_ok;
		logic pending;
	} res_stat_t;

endpackage

@@ rtl/core/multi_slot_timer_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multi_slot_timer_scheduler_core
// Table of 16 one-shot, recurring and limited timer slots driven by ticks.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Add, cancel and new-interval requests
// give one response with last set. A tick walks all 16 slots: a free slot
// is passed over, an active slot gets a memory read, then a read-modify-write
// and, where one is due, a final event; the walk then closes. The walk is
// paced by the single read port of the slot memories and by response
// backpressure. Activity bits sit in flip-flops and clear at reset; the
// per-slot timing and control fields live in two RAMs that are always written
// when a slot is added, so no clearing pass is needed. A quiet tick gives no
// response.
// ----------------------------------------------------------------------------
module multi_slot_timer_scheduler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [2:0]                     func,
	input  logic [mst_pkg::ID_BITS-1:0]    timer_id,
	input  logic [mst_pkg::TICK_BITS-1:0]  delay_ticks,
	input  logic [mst_pkg::COUNT_BITS-1:0] repeat_limit,
	input  logic                           wants_final,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [1:0]                     event_kind,
	output logic [mst_pkg::SLOT_BITS-1:0]  slot_id,
	output logic                           last
);
	import mst_pkg::*;

	// memory ports between controller and RAMs
	logic                 tmr_we;
	logic [SLOT_BITS-1:0] tmr_waddr;
	tmr_entry_t           tmr_wdata;
	tmr_entry_t           tmr_rdata;
	logic                 ctl_we;
	logic [SLOT_BITS-1:0] ctl_waddr;
	ctl_entry_t           ctl_wdata;
	ctl_entry_t           ctl_rdata;
	logic                 rd_en;
	logic [SLOT_BITS-1:0] rd_addr;

	res_req_t             res_req;
	res_stat_t            res_stat;

	// decode, allocation and tick walk
	mst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.timer_id     (timer_id),
		.delay_ticks  (delay_ticks),
		.repeat_limit (repeat_limit),
		.wants_final  (wants_final),
		.tmr_we       (tmr_we),
		.tmr_waddr    (tmr_waddr),
		.tmr_wdata    (tmr_wdata),
		.ctl_we       (ctl_we),
		.ctl_waddr    (ctl_waddr),
		.ctl_wdata    (ctl_wdata),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.tmr_rdata    (tmr_rdata),
		.ctl_rdata    (ctl_rdata),
		.res_req      (res_req),
		.res_stat     (res_stat)
	);

	// ticks left and reload interval per slot
	mst_ram #(
		.WIDTH (TMR_W),
		.DEPTH (NUM_SLOTS)
	) u_tmr_ram (
		.clk   (clk),
		.we    (tmr_we),
		.waddr (tmr_waddr),
		.wdata (tmr_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tmr_rdata)
	);

	// limit, count, mode and final flag per slot
	mst_ram #(
		.WIDTH (CTL_W),
		.DEPTH (NUM_SLOTS)
	) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (ctl_waddr),
		.wdata (ctl_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ctl_rdata)
	);

	// one-deep hold marks the last response, then the output register
	mst_res_stage u_res (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_req    (res_req),
		.res_stat   (res_stat),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.event_kind (event_kind),
		.slot_id    (slot_id),
		.last       (last)
	);

endmodule

@@ rtl/core/mst_ram.sv @@
// ----------------------------------------------------------------------------
// mst_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/mst_ctrl.sv @@
// ----------------------------------------------------------------------------
// mst_ctrl
// Request decode, slot allocation and the read-modify-write tick walk.
// ----------------------------------------------------------------------------
module mst_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [2:0]                    func,
	input  logic [mst_pkg::ID_BITS-1:0]   timer_id,
	input  logic [mst_pkg::TICK_BITS-1:0] delay_ticks,
	input  logic [mst_pkg::COUNT_BITS-1:0] repeat_limit,
	input  logic                          wants_final,
	output logic                          tmr_we,
	output logic [mst_pkg::SLOT_BITS-1:0] tmr_waddr,
	output mst_pkg::tmr_entry_t           tmr_wdata,
	output logic                          ctl_we,
	output logic [mst_pkg::SLOT_BITS-1:0] ctl_waddr,
	output mst_pkg::ctl_entry_t           ctl_wdata,
	output logic                          rd_en,
	output logic [mst_pkg::SLOT_BITS-1:0] rd_addr,
	input  mst_pkg::tmr_entry_t           tmr_rdata,
	input  mst_pkg::ctl_entry_t           ctl_rdata,
	output mst_pkg::res_req_t             res_req,
	input  mst_pkg::res_stat_t            res_stat
);
	import mst_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RESP, S_RD, S_EVAL, S_FIN, S_END
	} state_t;

	localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(NUM_SLOTS - 1);

	state_t                 state_q;
	logic [NUM_SLOTS-1:0]   active_q;
	logic [SLOT_BITS-1:0]   idx_q;
	logic [NRES_BITS-1:0]   nres_q;
	ev_kind_t               res_kind_q;
	logic [SLOT_BITS-1:0]   res_slot_q;

	logic                   accept;
	logic                   free_found;
	logic [SLOT_BITS-1:0]   free_idx;
	logic                   id_hit;
	ev_kind_t               acc_kind;
	logic [SLOT_BITS-1:0]   acc_slot;
	logic                   acc_set;
	logic                   acc_clr;
	logic [SLOT_BITS-1:0]   acc_idx;
	logic                   acc_wr_tmr;
	logic                   acc_wr_ctl;
	logic [1:0]             add_mode;

	logic                   cap_ok;
	logic                   ev1;
	ev_kind_t               ev1_kind;
	logic                   ev2;
	logic                   ev_clr;
	logic                   ev_wr_tmr;
	logic                   ev_wr_ctl;
	tmr_entry_t             ev_tmr;
	ctl_entry_t             ev_ctl;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic                   need1;
	logic                   go1;
	logic                   go2;
	logic                   last_slot;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign cap_ok    = nres_q < NRES_BITS'(MAX_RESULTS);
	assign last_slot = (idx_q == LAST_IDX);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_BITS'(i);
			end
		end
	end

	assign id_hit = ({1'b0, timer_id} < (ID_BITS + 1)'(NUM_SLOTS)) &&
		active_q[timer_id[SLOT_BITS-1:0]];

	always_comb begin
		case (func)
			FN_ADD_REP: add_mode = MODE_REPEAT;
			FN_ADD_LIM: add_mode = MODE_LIMITED;
			default:    add_mode = MODE_ONCE;
		endcase
	end

	// non-tick request decode
	always_comb begin
		acc_kind   = EV_REJECT;
		acc_slot   = '0;
		acc_set    = 1'b0;
		acc_clr    = 1'b0;
		acc_idx    = free_idx;
		acc_wr_tmr = 1'b0;
		acc_wr_ctl = 1'b0;
		case (func)
			FN_ADD_ONCE, FN_ADD_REP, FN_ADD_LIM: begin
				if (free_found) begin
					acc_kind   = EV_ACCEPT;
					acc_slot   = free_idx;
					acc_set    = 1'b1;
					acc_wr_tmr = 1'b1;
					acc_wr_ctl = 1'b1;
				end
			end
			FN_CANCEL, FN_NEW_IVL: begin
				acc_slot = timer_id[SLOT_BITS-1:0];
				acc_idx  = timer_id[SLOT_BITS-1:0];
				if (id_hit) begin
					acc_kind   = EV_ACCEPT;
					acc_clr    = (func == FN_CANCEL);
					acc_wr_tmr = (func == FN_NEW_IVL);
				end
			end
			default: begin
				acc_kind = EV_REJECT;
			end
		endcase
	end

	// per-slot tick update from the read data
	assign cnt_inc = ctl_rdata.count + COUNT_BITS'(1);

	always_comb begin
		ev1       = 1'b0;
		ev1_kind  = EV_FIRED;
		ev2       = 1'b0;
		ev_clr    = 1'b0;
		ev_wr_tmr = 1'b0;
		ev_wr_ctl = 1'b0;
		ev_tmr.ticks_left = tmr_rdata.reload;
		ev_tmr.reload     = tmr_rdata.reload;
		ev_ctl       = ctl_rdata;
		ev_ctl.count = cnt_inc;
		if (tmr_rdata.ticks_left > TICK_BITS'(1)) begin
			ev_wr_tmr         = 1'b1;
			ev_tmr.ticks_left = tmr_rdata.ticks_left - TICK_BITS'(1);
		end else begin
			case (ctl_rdata.mode)
				MODE_REPEAT: begin
					ev1       = 1'b1;
					ev_wr_tmr = 1'b1;
				end
				MODE_LIMITED: begin
					if (ctl_rdata.limit == '0) begin
						// zero limit: free without firing
						ev_clr   = 1'b1;
						ev1      = ctl_rdata.final_req;
						ev1_kind = EV_FINAL;
					end else begin
						ev1       = 1'b1;
						ev_wr_ctl = 1'b1;
						if (cnt_inc >= ctl_rdata.limit) begin
							ev_clr = 1'b1;
							ev2    = ctl_rdata.final_req;
						end else begin
							ev_wr_tmr = 1'b1;
						end
					end
				end
				default: begin
					ev1    = 1'b1;
					ev_clr = 1'b1;
				end
			endcase
		end
	end

	assign need1 = ev1 && cap_ok;
	assign go1   = !need1 || res_stat.room;
	assign go2   = !cap_ok || res_stat.room;

	// memory ports
	always_comb begin
		tmr_we    = 1'b0;
		tmr_waddr = idx_q;
		tmr_wdata = ev_tmr;
		ctl_we    = 1'b0;
		ctl_waddr = idx_q;
		ctl_wdata = ev_ctl;
		if (state_q == S_IDLE) begin
			tmr_we    = accept && (func != FN_TICK) && acc_wr_tmr;
			ctl_we    = accept && (func != FN_TICK) && acc_wr_ctl;
			tmr_waddr = acc_idx;
			ctl_waddr = acc_idx;
			tmr_wdata.ticks_left = delay_ticks;
			tmr_wdata.reload     = delay_ticks;
			ctl_wdata.limit      = (func == FN_ADD_LIM) ? repeat_limit : '0;
			ctl_wdata.count      = '0;
			ctl_wdata.mode       = add_mode;
			ctl_wdata.final_req  = (func == FN_ADD_LIM) && wants_final;
		end else if (state_q == S_EVAL) begin
			tmr_we = go1 && ev_wr_tmr;
			ctl_we = go1 && ev_wr_ctl;
		end
	end

	assign rd_en   = (state_q == S_RD) && active_q[idx_q];
	assign rd_addr = idx_q;

	// result requests
	always_comb begin
		res_req.push  = 1'b0;
		res_req.flush = 1'b0;
		res_req.kind  = ev1_kind;
		res_req.slot  = idx_q;
		case (state_q)
			S_RESP: begin
				res_req.push = res_stat.room;
				res_req.kind = res_kind_q;
				res_req.slot = res_slot_q;
			end
			S_EVAL: begin
				res_req.push = go1 && need1;
			end
			S_FIN: begin
				res_req.push = go2 && cap_ok;
				res_req.kind = EV_FINAL;
			end
			S_END: begin
				res_req.flush = res_stat.pending && res_stat.flush_ok;
			end
			default: begin
				res_req.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			idx_q      <= '0;
			nres_q     <= '0;
			res_kind_q <= EV_REJECT;
			res_slot_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FN_TICK) begin
							idx_q   <= '0;
							nres_q  <= '0;
							state_q <= S_RD;
						end else begin
							res_kind_q <= acc_kind;
							res_slot_q <= acc_slot;
							state_q    <= S_RESP;
							if (acc_set) begin
								active_q[acc_idx] <= 1'b1;
							end
							if (acc_clr) begin
								active_q[acc_idx] <= 1'b0;
							end
						end
					end
				end
				S_RESP: begin
					if (res_stat.room) begin
						state_q <= S_END;
					end
				end
				S_RD: begin
					if (active_q[idx_q]) begin
						state_q <= S_EVAL;
					end else if (last_slot) begin
						state_q <= S_END;
					end else begin
						idx_q <= idx_q + SLOT_BITS'(1);
					end
				end
				S_EVAL: begin
					if (go1) begin
						if (need1) begin
							nres_q <= nres_q + NRES_BITS'(1);
						end
						if (ev_clr) begin
							active_q[idx_q] <= 1'b0;
						end
						if (ev2) begin
							state_q <= S_FIN;
						end else if (last_slot) begin
							state_q <= S_END;
						end else begin
							idx_q   <= idx_q + SLOT_BITS'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (go2) begin
						if (cap_ok) begin
							nres_q <= nres_q + NRES_BITS'(1);
						end
						if (last_slot) begin
							state_q <= S_END;
						end else begin
							idx_q   <= idx_q + SLOT_BITS'(1);
							state_q <= S_RD;
						end
					end
				end
				S_END: begin
					if (!res_stat.pending || res_stat.flush_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/mst_res_stage.sv @@
// ----------------------------------------------------------------------------
// mst_res_stage
// Holds one result back to mark the last one, then the output register.
// ----------------------------------------------------------------------------
module mst_res_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mst_pkg::res_req_t             res_req,
	output mst_pkg::res_stat_t            res_stat,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [1:0]                    event_kind,
	output logic [mst_pkg::SLOT_BITS-1:0] slot_id,
	output logic                          last
);
	import mst_pkg::*;

	logic                 hold_valid_q;
	ev_kind_t             hold_kind_q;
	logic [SLOT_BITS-1:0] hold_slot_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [SLOT_BITS-1:0] out_slot_q;
	logic                 out_last_q;
	logic                 out_free;
	logic                 load_out;

	assign out_free = !out_valid_q || rsp_ready;
	assign load_out = (res_req.push && hold_valid_q) || res_req.flush;

	assign res_stat.room     = !hold_valid_q || out_free;
	assign res_stat.flush_ok = out_free;
	assign res_stat.pending  = hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (res_req.push) begin
				hold_valid_q <= 1'b1;
			end else if (res_req.flush) begin
				hold_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_req.push) begin
			hold_kind_q <= res_req.kind;
			hold_slot_q <= res_req.slot;
		end
		if (load_out) begin
			out_kind_q <= hold_kind_q;
			out_slot_q <= hold_slot_q;
			out_last_q <= res_req.flush;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign event_kind = out_kind_q;
	assign slot_id    = out_slot_q;
	assign last       = out_last_q;

endmodule

@@ rtl/core/mst_checker.sv @@
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks of the timer scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [2:0]                     func,
	input logic [mst_pkg::ID_BITS-1:0]    timer_id,
	input logic [mst_pkg::TICK_BITS-1:0]  delay_ticks,
	input logic [mst_pkg::COUNT_BITS-1:0] repeat_limit,
	input logic                           wants_final,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [1:0]                     event_kind,
	input logic [mst_pkg::SLOT_BITS-1:0]  slot_id,
	input logic                           last
);
	import mst_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind) &&
		$stable(slot_id) && $stable(last))
		else $error("stalled response changed");

	// accept and reject responses are single and thus last
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (event_kind == EV_ACCEPT || event_kind == EV_REJECT) |-> last)
		else $error("accept/reject response without last");

	// a request keeps the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken on back-to-back cycles");

	// a waiting request holds its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(func) &&
		$stable(timer_id) && $stable(delay_ticks) && $stable(repeat_limit) &&
		$stable(wants_final))
		else $error("waiting request changed");

	// a valid response carries known fields
	a_rsp_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !$isunknown({event_kind, slot_id, last}))
		else $error("response with unknown fields");

endmodule

bind multi_slot_timer_scheduler_core mst_checker u_mst_checker (.*);
